### rtl/core/smr_pkg.sv
`default_nettype none

package smr_pkg;

    // fixed field widths
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned TOTAL_W  = 7;

    // request codes
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic                valid_res;
        logic [SAMPLE_W-1:0] median_value;
        logic [SAMPLE_W-1:0] minimum_value;
        logic [SAMPLE_W-1:0] maximum_value;
        logic [TOTAL_W-1:0]  sample_total;
    } out_item_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the incoming sample in sorted order
        logic drain;    // shift the whole row one place towards cell 0
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/smr_cell.sv
`default_nettype none

module smr_cell (
    input  wire logic                                clk,
    input  wire smr_pkg::cell_ctrl_t                 ctrl,
    input  wire logic [smr_pkg::SAMPLE_W-1:0]        sample,
    input  wire logic                                occupied,
    input  wire logic                                tail,
    input  wire logic [smr_pkg::SAMPLE_W-1:0]        left_data,
    input  wire logic                                left_gt,
    input  wire logic [smr_pkg::SAMPLE_W-1:0]        right_data,
    output logic      [smr_pkg::SAMPLE_W-1:0]        data,
    output logic                                     gt
);

    logic [smr_pkg::SAMPLE_W-1:0] data_reg;
    logic [smr_pkg::SAMPLE_W-1:0] data_next;
    logic                         take;

    // held value strictly above the newcomer: newcomer goes before it
    assign gt   = occupied && (data_reg > sample);
    assign take = ctrl.insert && (gt || tail);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.drain)
        begin
            data_next = right_data;
        end
        else if (take)
        begin
            data_next = left_gt ? left_data : sample;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### rtl/core/sample_median_and_range.sv
`default_nettype none

// Sample median and range. Add transactions (req_type = add) place one 16.16
// sample into a sorted insertion chain of MAX_HELD cells; while busy is low,
// adds may be issued back to back, and adds beyond MAX_HELD are dropped.
// A finish transaction with n held samples raises busy while the chain
// drains through cell 0 (min, middle values and max are picked off as they
// pass); the result strobes on done in the cycle after the last drain cycle.
// A finish on an empty set returns valid_res = 0 with zero fields on the
// next cycle and never raises busy. done is high for a single cycle with
// the result on res; the receiver cannot stall, so capture it then. A new
// transaction may be issued in the same cycle as done.
module sample_median_and_range #(
    parameter int unsigned MAX_HELD = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire smr_pkg::in_item_t   cmd,
    output logic                     done,
    output smr_pkg::out_item_t       res
);

    localparam int unsigned CW = $clog2(MAX_HELD + 1);   // count width
    localparam int unsigned KW = $clog2(MAX_HELD);       // drain step width

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                          state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 n_reg, n_next;        // size of set being drained
    logic [KW-1:0]                 step_reg, step_next;  // rank now sitting in cell 0
    logic [smr_pkg::SAMPLE_W-1:0]  min_reg, min_next;
    logic [smr_pkg::SAMPLE_W-1:0]  lo_reg, lo_next;      // lower middle, even counts
    logic [smr_pkg::SAMPLE_W-1:0]  med_reg, med_next;
    logic                          done_reg, done_next;
    smr_pkg::out_item_t            res_reg, res_next;

    smr_pkg::cell_ctrl_t           ctrl;
    logic                          accept;

    logic [smr_pkg::SAMPLE_W-1:0]  cell_data [MAX_HELD];
    logic                          cell_gt   [MAX_HELD];

    assign accept = start && !busy;
    assign busy   = (state_reg == ST_DRAIN);

    // ------------------------------------------------------------------
    // Insertion chain
    // ------------------------------------------------------------------
    assign ctrl.insert = accept && (cmd.req_type == smr_pkg::REQ_ADD)
                         && (count_reg < CW'(MAX_HELD));
    assign ctrl.drain  = (state_reg == ST_DRAIN);

    for (genvar i = 0; i < MAX_HELD; i++)
    begin : g_cell
        logic [smr_pkg::SAMPLE_W-1:0] left_data;
        logic                         left_gt;
        logic [smr_pkg::SAMPLE_W-1:0] right_data;

        if (i == 0)
        begin : g_head
            assign left_data = '0;
            assign left_gt   = 1'b0;
        end
        else
        begin : g_body
            assign left_data = cell_data[i-1];
            assign left_gt   = cell_gt[i-1];
        end

        if (i == MAX_HELD - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid
            assign right_data = cell_data[i+1];
        end

        smr_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .sample     (cmd.sample),
            .occupied   (CW'(i) < count_reg),
            .tail       (CW'(i) == count_reg),
            .left_data  (left_data),
            .left_gt    (left_gt),
            .right_data (right_data),
            .data       (cell_data[i]),
            .gt         (cell_gt[i])
        );
    end

    // ------------------------------------------------------------------
    // Readout sequencer: picks statistics off cell 0 as the chain drains
    // ------------------------------------------------------------------
    logic [CW-1:0]                 step_ext;
    logic [CW-1:0]                 mid;
    logic                          n_odd;
    logic [smr_pkg::SAMPLE_W:0]    pair_sum;
    logic [smr_pkg::SAMPLE_W-1:0]  med_now;
    logic [smr_pkg::SAMPLE_W-1:0]  min_now;
    logic                          at_mid;

    assign step_ext = CW'(step_reg);
    assign mid      = n_reg >> 1;
    assign n_odd    = n_reg[0];
    assign at_mid   = (step_ext == mid);
    assign pair_sum = {1'b0, lo_reg} + {1'b0, cell_data[0]};
    // odd: middle value itself; even: truncated mean of the two middles
    assign med_now  = n_odd ? cell_data[0] : pair_sum[smr_pkg::SAMPLE_W:1];
    assign min_now  = (step_reg == '0) ? cell_data[0] : min_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        min_next   = min_reg;
        lo_next    = lo_reg;
        med_next   = med_reg;
        done_next  = 1'b0;
        res_next   = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.insert)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (accept && (cmd.req_type == smr_pkg::REQ_FINISH))
                begin
                    count_next = '0;
                    if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                        res_next  = '0;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                        n_next     = count_reg;
                        step_next  = '0;
                    end
                end
            end

            ST_DRAIN:
            begin
                min_next = min_now;
                if (!n_odd && (step_ext == mid - 1'b1))
                begin
                    lo_next = cell_data[0];
                end
                if (at_mid)
                begin
                    med_next = med_now;
                end
                if (step_ext == n_reg - 1'b1)
                begin
                    state_next             = ST_IDLE;
                    done_next              = 1'b1;
                    res_next.valid_res     = 1'b1;
                    res_next.median_value  = at_mid ? med_now : med_reg;
                    res_next.minimum_value = min_now;
                    res_next.maximum_value = cell_data[0];
                    res_next.sample_total  = smr_pkg::TOTAL_W'(n_reg);
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        step_reg <= step_next;
        min_reg  <= min_next;
        lo_reg   <= lo_next;
        med_reg  <= med_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_HELD))
        else $error("held count above capacity");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (count_reg == '0))
        else $error("set not cleared while draining");

    a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) && (step_ext == n_reg - 1'b1) |=>
            done_reg && res_reg.valid_res && (state_reg == ST_IDLE))
        else $error("drain did not end in a result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !res_reg.valid_res |->
            (res_reg.median_value == '0) && (res_reg.minimum_value == '0)
            && (res_reg.maximum_value == '0) && (res_reg.sample_total == '0))
        else $error("invalid result carries non-zero fields");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_reg.valid_res |->
            (res_reg.minimum_value <= res_reg.median_value)
            && (res_reg.median_value <= res_reg.maximum_value))
        else $error("min, median, max out of order");
`endif

endmodule

`default_nettype wire
